// ===== rtl/core/ssd_pkg.sv =====
// Shared constants for the sorted set difference block: field widths,
// operation codes and result categories. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    localparam int SET_CAPACITY_DEF = 32;
    localparam int KEY_W            = 64;
    localparam int OP_W             = 2;
    localparam int CAT_W            = 2;

    // op codes (op 3 is ignored)
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    // result categories
    localparam logic [CAT_W-1:0] CAT_REMOVED   = 2'd0;
    localparam logic [CAT_W-1:0] CAT_ADDED     = 2'd1;
    localparam logic [CAT_W-1:0] CAT_UNCHANGED = 2'd2;
    localparam logic [CAT_W-1:0] CAT_EMPTY     = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_set_difference.sv =====
// Sorted set difference: two key stores kept sorted by insertion, merged on finish.
// Depends on ssd_pkg.
//
// Usage
//   Input stream s_axis: tuser carries op (load A, load B, finish), tdata the 64-bit key.
//   Output stream m_axis: tdata carries the classified key, tuser the category and
//   the overflow flag, tlast marks the final beat of one finish.
//   Load beats keep each store sorted: the new key is walked down from the top of
//   its store by one shared 64-bit comparator, one entry per cycle through the
//   store's registered read port. A load into an empty or a full store leaves
//   s_axis_tready high; otherwise it stays low until the key is in its slot.
//   A full store drops the key and sets the overflow flag, which every result beat
//   of the next finish carries.
//   A finish merges both stores with the same comparator, each result beat taking
//   one store read (ST_MRD) and one compare (ST_MCMP). Both stores empty yields
//   a single marker beat (key 0, category empty).
//   After the last beat of a finish the counts and the flag clear.
//   Results sit in an output register; when m_axis_tready is low the merge holds
//   with the pending beat stable. A new input beat is taken as soon as the
//   sequencer is idle, even while the final result still waits to be taken.
//   Reset (rst_n low) empties both stores and clears the flag and output valid;
//   store contents are not cleared, only entries below each count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_difference
    import ssd_pkg::*;
#(
    parameter int SET_CAPACITY = SET_CAPACITY_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [KEY_W-1:0]  s_axis_tdata,   // [63:0] key
    input  wire logic [OP_W-1:0]   s_axis_tuser,   // [1:0] op
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [KEY_W-1:0]       m_axis_tdata,   // [63:0] result_key
    output logic [CAT_W:0]         m_axis_tuser,   // [1:0] category, [2] overflowed
    output logic                   m_axis_tlast
);

    localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
    localparam int ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // ready for a beat
    localparam logic [2:0] ST_INS   = 3'd1;  // insertion compare / shift step
    localparam logic [2:0] ST_PUT   = 3'd2;  // drop key into slot 0
    localparam logic [2:0] ST_MRD   = 3'd3;  // merge: store reads in flight
    localparam logic [2:0] ST_MCMP  = 3'd4;  // merge: compare and emit
    localparam logic [2:0] ST_EMPTY = 3'd5;  // emit empty marker

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] j_reg, j_next;      // free slot during insertion
    logic             sel_reg, sel_next;  // store under insertion: 0 A, 1 B
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] ia_reg, ia_next;
    logic [CNT_W-1:0] ib_reg, ib_next;

    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] out_key_reg, out_key_next;
    logic [CAT_W-1:0] out_cat_reg, out_cat_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_last_reg, out_last_next;

    // key stores, one write and one read port each, registered read
    logic [KEY_W-1:0] mem_a [SET_CAPACITY];
    logic [KEY_W-1:0] mem_b [SET_CAPACITY];
    logic [KEY_W-1:0] rd_a_reg, rd_b_reg;
    logic             we_a, we_b;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b, ins_addr;
    logic              ins_rd;
    logic [KEY_W-1:0]  wr_data;

    // shared comparator
    logic [KEY_W-1:0] cmp_x, cmp_y;
    logic             cmp_gt, cmp_eq;

    logic             accept, out_free;
    logic [CNT_W-1:0] cnt_sel, cnt_sel_dec, j_dec, j_dec2, ia_inc, ib_inc;
    logic             a_ok, b_ok;
    logic [KEY_W-1:0] rd_sel;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign cnt_sel     = s_axis_tuser[0] ? cnt_b_reg : cnt_a_reg;
    assign cnt_sel_dec = cnt_sel - CNT_ONE;
    assign j_dec       = j_reg - CNT_ONE;
    assign j_dec2      = j_reg - CNT_TWO;
    assign ia_inc      = ia_reg + CNT_ONE;
    assign ib_inc      = ib_reg + CNT_ONE;
    assign a_ok        = ia_reg < cnt_a_reg;
    assign b_ok        = ib_reg < cnt_b_reg;
    assign rd_sel      = sel_reg ? rd_b_reg : rd_a_reg;

    // insertion: stored > key; merge: b > a
    assign cmp_x  = (state_reg == ST_INS) ? rd_sel  : rd_b_reg;
    assign cmp_y  = (state_reg == ST_INS) ? key_reg : rd_a_reg;
    assign cmp_gt = cmp_x > cmp_y;
    assign cmp_eq = cmp_x == cmp_y;

    assign rd_addr_a = ins_rd ? ins_addr : ia_reg[ADDR_W-1:0];
    assign rd_addr_b = ins_rd ? ins_addr : ib_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (we_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        sel_next       = sel_reg;
        key_next       = key_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_key_next   = out_key_reg;
        out_cat_next   = out_cat_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        we_a           = 1'b0;
        we_b           = 1'b0;
        wr_addr        = j_reg[ADDR_W-1:0];
        wr_data        = key_reg;
        ins_rd         = 1'b0;
        ins_addr       = j_dec2[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == OP_LOAD_A || s_axis_tuser == OP_LOAD_B)
                    begin
                        if (cnt_sel == CAP_CNT)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            key_next = s_axis_tdata;
                            sel_next = s_axis_tuser[0];
                            j_next   = cnt_sel;
                            if (s_axis_tuser[0])
                            begin
                                cnt_b_next = cnt_b_reg + CNT_ONE;
                            end
                            else
                            begin
                                cnt_a_next = cnt_a_reg + CNT_ONE;
                            end
                            if (cnt_sel == '0)
                            begin
                                // empty store: key lands in slot 0 at once
                                we_a    = !s_axis_tuser[0];
                                we_b    = s_axis_tuser[0];
                                wr_addr = '0;
                                wr_data = s_axis_tdata;
                            end
                            else
                            begin
                                ins_rd     = 1'b1;
                                ins_addr   = cnt_sel_dec[ADDR_W-1:0];
                                state_next = ST_INS;
                            end
                        end
                    end
                    else if (s_axis_tuser == OP_FINISH)
                    begin
                        ia_next = '0;
                        ib_next = '0;
                        if (cnt_a_reg == '0 && cnt_b_reg == '0)
                        begin
                            state_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_MRD;
                        end
                    end
                end
            end

            ST_INS:
            begin
                we_a = !sel_reg;
                we_b = sel_reg;
                if (cmp_gt)
                begin
                    // shift the larger entry up one slot
                    wr_data = rd_sel;
                    j_next  = j_dec;
                    if (j_dec == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ins_rd = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PUT:
            begin
                we_a       = !sel_reg;
                we_b       = sel_reg;
                state_next = ST_IDLE;
            end

            ST_MRD:
            begin
                state_next = ST_MCMP;
            end

            ST_MCMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = ovf_reg;
                    if (!b_ok || (a_ok && cmp_gt))
                    begin
                        out_key_next = rd_a_reg;
                        out_cat_next = CAT_REMOVED;
                        ia_next      = ia_inc;
                    end
                    else if (!a_ok || !cmp_eq)
                    begin
                        out_key_next = rd_b_reg;
                        out_cat_next = CAT_ADDED;
                        ib_next      = ib_inc;
                    end
                    else
                    begin
                        out_key_next = rd_a_reg;
                        out_cat_next = CAT_UNCHANGED;
                        ia_next      = ia_inc;
                        ib_next      = ib_inc;
                    end
                    if (ia_next == cnt_a_reg && ib_next == cnt_b_reg)
                    begin
                        out_last_next = 1'b1;
                        cnt_a_next    = '0;
                        cnt_b_next    = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        state_next    = ST_MRD;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    out_cat_next   = CAT_EMPTY;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        sel_reg      <= sel_next;
        key_reg      <= key_next;
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        out_key_reg  <= out_key_next;
        out_cat_reg  <= out_cat_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_key_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_cat_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ssd_chk.sv =====
// Port-level checks for sorted_set_difference, attached by bind.
// Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_chk
    import ssd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [KEY_W-1:0] m_axis_tdata,
    input wire logic [CAT_W:0]   m_axis_tuser,
    input wire logic             m_axis_tlast
);

    // a stalled result beat stays up
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // the empty marker always carries tlast
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[CAT_W-1:0] == CAT_EMPTY |-> m_axis_tlast)
        else $error("empty marker without tlast");

    // the empty marker carries key zero
    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[CAT_W-1:0] == CAT_EMPTY |-> m_axis_tdata == '0)
        else $error("empty marker with nonzero key");

endmodule

bind sorted_set_difference ssd_chk u_ssd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/sorted_set_difference_checker.sv =====
// Checker for the sorted set difference block: watches both streams, keeps its own
// copy of the two key sets and queues the classified keys each finish must produce.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module sorted_set_difference_checker
    import ssd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [KEY_W-1:0]  s_axis_tdata,   // [63:0] key
    input  wire logic [OP_W-1:0]   s_axis_tuser,   // [1:0] op
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [KEY_W-1:0]  m_axis_tdata,   // [63:0] result_key
    input  wire logic [CAT_W:0]    m_axis_tuser,   // [1:0] category, [2] overflowed
    input  wire logic              m_axis_tlast,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CAT_W-1:0] cat;
        logic             ovf;
        logic             last;
    } diff_beat_t;

    logic [KEY_W-1:0] old_keys[$];
    logic [KEY_W-1:0] new_keys[$];
    logic             drop_seen;
    diff_beat_t       pending_diffs[$];
    diff_beat_t       want;
    diff_beat_t       got;

    // Sort both sets, walk them side by side and queue one beat per key (or per
    // matched pair). Clears the sets and the drop flag afterwards.
    function automatic void classify_merge();
        logic [KEY_W-1:0] a[$];
        logic [KEY_W-1:0] b[$];
        int               ia;
        int               ib;
        diff_beat_t       d;
        a = old_keys;
        b = new_keys;
        a.sort();
        b.sort();
        ia = 0;
        ib = 0;
        if (a.size() == 0 && b.size() == 0)
        begin
            d.key  = '0;
            d.cat  = CAT_EMPTY;
            d.ovf  = drop_seen;
            d.last = 1'b1;
            pending_diffs.push_back(d);
        end
        while (ia < a.size() || ib < b.size())
        begin
            if (ib >= b.size() || (ia < a.size() && a[ia] < b[ib]))
            begin
                d.key = a[ia];
                d.cat = CAT_REMOVED;
                ia++;
            end
            else if (ia >= a.size() || a[ia] > b[ib])
            begin
                d.key = b[ib];
                d.cat = CAT_ADDED;
                ib++;
            end
            else
            begin
                d.key = a[ia];
                d.cat = CAT_UNCHANGED;
                ia++;
                ib++;
            end
            d.ovf  = drop_seen;
            d.last = (ia == a.size() && ib == b.size());
            pending_diffs.push_back(d);
        end
        old_keys.delete();
        new_keys.delete();
        drop_seen = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_keys.delete();
            new_keys.delete();
            pending_diffs.delete();
            drop_seen   = 1'b0;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // result side first: any beat seen here belongs to an earlier finish
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.key  = m_axis_tdata;
                got.cat  = m_axis_tuser[CAT_W-1:0];
                got.ovf  = m_axis_tuser[CAT_W];
                got.last = m_axis_tlast;
                if (pending_diffs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no beat, got key=%h cat=%0d ovf=%0b last=%0b",
                             $time, got.key, got.cat, got.ovf, got.last);
                end
                else
                begin
                    want = pending_diffs.pop_front();
                    if (got.key !== want.key || got.cat !== want.cat ||
                        got.ovf !== want.ovf || got.last !== want.last)
                    begin
                        mismatches++;
                        $display({"%0t: expected key=%h cat=%0d ovf=%0b last=%0b,",
                                  " got key=%h cat=%0d ovf=%0b last=%0b"},
                                 $time, want.key, want.cat, want.ovf, want.last,
                                 got.key, got.cat, got.ovf, got.last);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_LOAD_A:
                        if (old_keys.size() < SET_CAPACITY_DEF)
                            old_keys.push_back(s_axis_tdata);
                        else
                            drop_seen = 1'b1;
                    OP_LOAD_B:
                        if (new_keys.size() < SET_CAPACITY_DEF)
                            new_keys.push_back(s_axis_tdata);
                        else
                            drop_seen = 1'b1;
                    OP_FINISH:
                        classify_merge();
                    default:
                        ;   // unused op: no effect
                endcase
            end

            outstanding = pending_diffs.size();
        end
    end

endmodule

// ===== tb/sv/sorted_set_difference_tb.sv =====
// Top of the sorted set difference testbench: clock, reset, stimulus, handshake
// pressure and verdict. Depends on ssd_pkg, sorted_set_difference and
// sorted_set_difference_checker.
`timescale 1ns / 1ps

module sorted_set_difference_tb;

    import ssd_pkg::*;

    // op code 3 has no name in the package; the block ignores it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 50;    // counted input beats per idling phase
    localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
    localparam int SETTLE      = 200;   // quiet cycles after the last result
    localparam int GAP_CAP     = 40;    // longest sender gap

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic [KEY_W-1:0] s_axis_tdata   = '0;       // [63:0] key
    logic [OP_W-1:0]  s_axis_tuser   = OP_LOAD_A; // [1:0] op
    logic             m_axis_tready  = 1'b0;
    wire              s_axis_tready;
    wire              m_axis_tvalid;
    wire [KEY_W-1:0]  m_axis_tdata;   // [63:0] result_key
    wire [CAT_W:0]    m_axis_tuser;   // [1:0] category, [2] overflowed
    wire              m_axis_tlast;

    int idle_pct   = 0;   // chance in 100 that the sender holds off another cycle
    int stall_pct  = 0;   // chance in 100 that the receiver stalls a cycle
    int load_count = 0;   // counted random beats (ignored op codes excluded)
    int quiet_cycles = 0;
    int mismatches;
    int outstanding;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    sorted_set_difference dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sorted_set_difference_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Receiver: a fresh ready decision every falling edge, at the phase's stall rate.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: ends the run if neither stream moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one beat and hold it until taken. Called and returns at a falling
    // edge; tvalid is only lowered when a gap is inserted, so back-to-back beats
    // keep it high without a second assignment in the same step.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Hold the input side idle until every queued result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Key flavors: a tiny pool (lots of duplicates and matches across sets),
    // extremes mixed with small values, or fully random 64-bit keys.
    function automatic logic [KEY_W-1:0] pick_key(input int flavor);
        case (flavor)
            0:       return KEY_W'($urandom_range(0, 7));
            1:
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, {(KEY_W-1){1'b0}}};
                    3:       return {1'b0, {(KEY_W-1){1'b1}}};
                    default: return KEY_W'($urandom_range(0, 3));
                endcase
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One load-then-finish sequence. Set sizes are mostly small; some runs fill
    // one or both stores past capacity so the drop flag gets exercised.
    task automatic run_sequence(input bit overfill_a);
        int na;
        int nb;
        int pick;
        int flavor;
        pick   = $urandom_range(0, 99);
        flavor = $urandom_range(0, 2);
        if (overfill_a)
        begin
            na = SET_CAPACITY_DEF + 2;
            nb = $urandom_range(0, 3);
        end
        else if (pick < 6)
        begin
            na = 0;
            nb = 0;
        end
        else if (pick < 13)
        begin
            na = $urandom_range(SET_CAPACITY_DEF - 4, SET_CAPACITY_DEF + 3);
            nb = $urandom_range(0, 6);
        end
        else if (pick < 20)
        begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(SET_CAPACITY_DEF - 4, SET_CAPACITY_DEF + 3);
        end
        else if (pick < 23)
        begin
            // both stores full: the longest finish
            na = $urandom_range(SET_CAPACITY_DEF, SET_CAPACITY_DEF + 1);
            nb = $urandom_range(SET_CAPACITY_DEF, SET_CAPACITY_DEF + 1);
        end
        else
        begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
        end

        while (na > 0 || nb > 0)
        begin
            // occasional unused op code as noise; not counted
            if ($urandom_range(0, 99) < 3)
                send_beat(OP_UNUSED, pick_key(2));
            if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1))
            begin
                send_beat(OP_LOAD_A, pick_key(flavor));
                na--;
            end
            else
            begin
                send_beat(OP_LOAD_B, pick_key(flavor));
                nb--;
            end
            load_count++;
        end
        // key on a finish is ignored, so drive it random
        send_beat(OP_FINISH, pick_key(2));
        load_count++;
    endtask

    initial
    begin
        int phase;
        int phase_start;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // finish with both sets empty: single marker beat
        send_beat(OP_FINISH, '1);
        // unused op is dropped silently
        send_beat(OP_UNUSED, '1);
        // extremes, a duplicate in A and matches at both ends of the range
        send_beat(OP_LOAD_A, '0);
        send_beat(OP_LOAD_A, '1);
        send_beat(OP_LOAD_A, {1'b1, {(KEY_W-1){1'b0}}});
        send_beat(OP_LOAD_B, '1);
        send_beat(OP_LOAD_B, 64'd1);
        send_beat(OP_LOAD_A, '0);
        send_beat(OP_LOAD_B, '0);
        send_beat(OP_FINISH, '0);
        // only B populated
        send_beat(OP_LOAD_B, 64'd5);
        send_beat(OP_FINISH, 64'h5555_aaaa_5555_aaaa);
        // duplicate key pairs off once, the spare copy is removed
        send_beat(OP_LOAD_A, 64'd7);
        send_beat(OP_LOAD_A, 64'd7);
        send_beat(OP_LOAD_B, 64'd7);
        send_beat(OP_FINISH, '0);
        // unused op between finishes leaves the sets empty
        send_beat(OP_UNUSED, 64'd5);
        send_beat(OP_FINISH, 64'haaaa_5555_aaaa_5555);
        wait_results_drained();

        // ---- random, four idling phases ----
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 85; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            phase_start = load_count;
            // first sequence of the run always overfills set A
            run_sequence(phase == 0);
            while (load_count - phase_start < PHASE_ITEMS)
                run_sequence(1'b0);
            // sender holds off until all results are back
            wait_results_drained();
        end

        stall_pct = 0;
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
